>>> rtl/core/wsfp_pkg.sv
// Types and constants shared by the WebSocket frame parser modules.
package wsfp_pkg;

  localparam int unsigned TDATA_W = 120;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [3:0] LEN_CNT16 = 4'd2;
  localparam logic [3:0] LEN_CNT64 = 4'd8;
  localparam logic [3:0] KEY_LEN   = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    PH_B0  = 3'd0,
    PH_B1  = 3'd1,
    PH_LEN = 3'd2,
    PH_KEY = 3'd3,
    PH_PAY = 3'd4
  } phase_e;

  typedef struct packed {
    logic       fin;
    logic       rsv1;
    logic       rsv2;
    logic       rsv3;
    logic [3:0] opcode;
    logic       masked;
  } hdr_t;

  typedef struct packed {
    logic        kind;
    hdr_t        hdr;
    logic [63:0] pay_len;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

>>> rtl/core/wsfp_deframer.sv
// Frame header decode, key capture and payload unmasking state machine.
module wsfp_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              emit_o,
  output wsfp_pkg::result_t result_o
);
  import wsfp_pkg::*;

  phase_e      phase_q, phase_d;
  hdr_t        hdr_q, hdr_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [63:0] rem_q, rem_d;
  logic [1:0]  kidx_q, kidx_d;

  logic        after_len;
  logic        hdr_done;
  logic        last;
  logic        kind;
  logic [7:0]  pbyte;
  logic [1:0]  kpos;
  logic [7:0]  kbyte;

  assign kpos  = 2'(KEY_LEN - cnt_q);
  assign kbyte = 8'(key_q >> {kidx_q, 3'b000});

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    rem_d     = rem_q;
    kidx_d    = kidx_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    emit_o    = 1'b0;
    last      = 1'b0;
    kind      = KIND_HEADER;
    pbyte     = 8'h00;
    case (phase_q)
      PH_B1: begin
        hdr_d.masked = byte_i[7];
        if (byte_i[6:0] < LEN_EXT16) begin
          len_d     = {57'd0, byte_i[6:0]};
          after_len = 1'b1;
        end else begin
          len_d   = '0;
          phase_d = PH_LEN;
          cnt_d   = (byte_i[6:0] == LEN_EXT16) ? LEN_CNT16 : LEN_CNT64;
        end
      end
      PH_LEN: begin
        len_d = {len_q[55:0], byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_d == 4'd0) after_len = 1'b1;
      end
      PH_KEY: begin
        key_d = key_q | ({24'd0, byte_i} << {kpos, 3'b000});
        cnt_d = cnt_q - 4'd1;
        if (cnt_d == 4'd0) hdr_done = 1'b1;
      end
      PH_PAY: begin
        pbyte  = hdr_q.masked ? (byte_i ^ kbyte) : byte_i;
        kidx_d = kidx_q + 2'd1;
        rem_d  = rem_q - 64'd1;
        last   = (rem_d == '0);
        kind   = KIND_PAYLOAD;
        emit_o = 1'b1;
        if (last) phase_d = PH_B0;
      end
      default: begin
        // first header byte; unused phase codes land here too
        hdr_d.fin    = byte_i[7];
        hdr_d.rsv1   = byte_i[6];
        hdr_d.rsv2   = byte_i[5];
        hdr_d.rsv3   = byte_i[4];
        hdr_d.opcode = byte_i[3:0];
        hdr_d.masked = 1'b0;
        len_d        = '0;
        cnt_d        = '0;
        key_d        = '0;
        rem_d        = '0;
        kidx_d       = '0;
        phase_d      = PH_B1;
      end
    endcase

    if (after_len) begin
      if (hdr_d.masked) begin
        phase_d = PH_KEY;
        cnt_d   = KEY_LEN;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      rem_d   = len_d;
      kidx_d  = '0;
      emit_o  = 1'b1;
      last    = (len_d == '0);
      phase_d = last ? PH_B0 : PH_PAY;
    end
  end

  assign result_o.kind         = kind;
  assign result_o.hdr          = hdr_d;
  assign result_o.pay_len      = len_d;
  assign result_o.mask_key     = key_d;
  assign result_o.payload_byte = pbyte;
  assign result_o.last         = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_B0;
      hdr_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
      rem_q   <= '0;
      kidx_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      kidx_q  <= kidx_d;
    end
  end

  a_pay_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

  a_field_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN || phase_q == PH_KEY) |-> (cnt_q != 4'd0))
    else $error("length or key field with zero byte count");

  a_last_b0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o && result_o.last) |=> (phase_q == PH_B0))
    else $error("frame end did not return to first header byte");

  a_kidx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_PAY) |=> (kidx_q == $past(kidx_q) + 2'd1))
    else $error("key index did not advance on payload byte");

endmodule

>>> rtl/core/wsfp_out_reg.sv
// Result register and stream output packing.
module wsfp_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          emit_i,
  input  wsfp_pkg::result_t             result_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // fin, rsv1, rsv2, rsv3, opcode[3:0], masked, pay_len[63:0],
  // mask_key[31:0], payload_byte[7:0], zero fill
  output logic [wsfp_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  // kind
  output logic [0:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import wsfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = load_i ? emit_i : (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.payload_byte, res_q.mask_key,
                            res_q.pay_len, res_q.hdr.masked,
                            res_q.hdr.opcode, res_q.hdr.rsv3, res_q.hdr.rsv2,
                            res_q.hdr.rsv1, res_q.hdr.fin};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;

endmodule

>>> rtl/core/websocket_frame_parser_top.sv
// WebSocket frame parser: input byte register, deframer and result register.
// Each byte is registered in the input byte register, and its result in the result register.
// Throughput: one byte per cycle; the input register and result register
// advance together whenever the result register is empty or being drained.
// Header and length/key bytes give no result except the byte that completes
// the header, which gives the header result; each payload byte gives one.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to awaiting the first header byte.
module websocket_frame_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // data_byte
  input  logic [7:0]                   s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // fin, rsv1, rsv2, rsv3, opcode[3:0], masked, pay_len[63:0],
  // mask_key[31:0], payload_byte[7:0], zero fill
  output logic [wsfp_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // kind
  output logic [0:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import wsfp_pkg::*;

  logic    in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic    out_free;
  logic    advance;
  logic    s_xfer;
  logic    emit;
  result_t result;

  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_xfer ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  wsfp_deframer u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .emit_o   (emit),
    .result_o (result)
  );

  wsfp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .emit_i          (emit),
    .result_i        (result),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> test/tb_websocket_frame_parser_top.sv
// Testbench for the WebSocket frame parser: byte stream in, header/payload results out.
`timescale 1ns / 1ps

module tb_websocket_frame_parser_top;
  import wsfp_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 700;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // data_byte
  logic                m_tvalid;
  logic                m_tready;
  // fin, rsv1, rsv2, rsv3, opcode[3:0], masked, pay_len[63:0],
  // mask_key[31:0], payload_byte[7:0], zero fill
  logic [TDATA_W-1:0]  m_tdata;
  logic [0:0]          m_tuser;   // kind
  logic                m_tlast;

  websocket_frame_parser_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // deframer mirror
  phase_e      ph;
  hdr_t        hdr;
  logic [63:0] len_acc;
  logic [3:0]  fld_cnt;
  logic [31:0] key;
  logic [63:0] remaining;
  logic [1:0]  kidx;

  result_t expected_results[$];
  int unsigned err_cnt;
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned rx_hold_len;
  rx_mode_e    rx_mode;

  function automatic void push_result(logic kind, logic [7:0] pbyte, logic last);
    result_t r;
    r.kind         = kind;
    r.hdr          = hdr;
    r.pay_len      = len_acc;
    r.mask_key     = key;
    r.payload_byte = pbyte;
    r.last         = last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void finish_header();
    remaining = len_acc;
    kidx      = 2'd0;
    push_result(KIND_HEADER, 8'h00, remaining == 64'd0);
    ph = (remaining == 64'd0) ? PH_B0 : PH_PAY;
  endfunction

  function automatic void finish_length();
    if (hdr.masked) begin
      ph      = PH_KEY;
      fld_cnt = KEY_LEN;
    end else begin
      finish_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] v;
    logic [1:0] pos;
    case (ph)
      PH_B1: begin
        hdr.masked = b[7];
        len_acc    = 64'd0;
        if (b[6:0] < LEN_EXT16) begin
          len_acc = {57'd0, b[6:0]};
          finish_length();
        end else begin
          ph      = PH_LEN;
          fld_cnt = (b[6:0] == LEN_EXT16) ? LEN_CNT16 : LEN_CNT64;
        end
      end
      PH_LEN: begin
        len_acc = {len_acc[55:0], b};
        fld_cnt = fld_cnt - 4'd1;
        if (fld_cnt == 4'd0) finish_length();
      end
      PH_KEY: begin
        pos     = 2'(KEY_LEN - fld_cnt);
        key     = key | ({24'd0, b} << (8 * pos));
        fld_cnt = fld_cnt - 4'd1;
        if (fld_cnt == 4'd0) finish_header();
      end
      PH_PAY: begin
        v = b;
        if (hdr.masked) v = v ^ key[8 * kidx +: 8];
        kidx      = kidx + 2'd1;
        remaining = remaining - 64'd1;
        push_result(KIND_PAYLOAD, v, remaining == 64'd0);
        if (remaining == 64'd0) ph = PH_B0;
      end
      default: begin
        // unused phase codes fall back to the first header byte
        hdr       = {b[7], b[6], b[5], b[4], b[3:0], 1'b0};
        len_acc   = 64'd0;
        fld_cnt   = 4'd0;
        key       = 32'd0;
        remaining = 64'd0;
        kidx      = 2'd0;
        ph        = PH_B1;
      end
    endcase
  endfunction

  // one byte transfer; the sender runs in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_frame(input logic [7:0] b0, input logic msk, input len_form_e form,
                            input logic [63:0] len, input logic [31:0] mkey,
                            input int unsigned n_pay);
    int i;
    send_byte(b0);
    case (form)
      FORM_SHORT: send_byte({msk, len[6:0]});
      FORM_EXT16: begin
        send_byte({msk, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({msk, LEN_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (msk) for (i = 0; i < 4; i++) send_byte(mkey[8 * i +: 8]);
    for (i = 0; i < int'(n_pay); i++) send_byte(8'($urandom));
  endtask

  // sender holds off until every expected result is out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_frames();
    rx_mode = RX_ALWAYS;
    send_frame(8'h89, 1'b0, FORM_SHORT, 64'd0, 32'd0, 0);
    send_frame(8'h8A, 1'b1, FORM_SHORT, 64'd0, 32'hDEADBEEF, 0);
    drain_results();
  endtask

  task automatic test_masked_payload();
    rx_mode = RX_PATTERN;
    send_frame(8'h7F, 1'b1, FORM_SHORT, 64'd2, 32'h5AA500FF, 2);
    send_frame(8'h00, 1'b0, FORM_SHORT, 64'd1, 32'd0, 1);
    drain_results();
  endtask

  task automatic test_extended_lengths();
    rx_mode = RX_RANDOM;
    send_frame(8'h82, 1'b0, FORM_EXT16, 64'd2, 32'd0, 2);
    send_frame(8'h01, 1'b0, FORM_EXT64, 64'd1, 32'd0, 1);
    drain_results();
  endtask

  task automatic test_backpressure();
    rx_mode     = RX_ALWAYS;
    rx_hold_len = 200;
    send_frame(8'h82, 1'b1, FORM_SHORT, 64'd30, 32'($urandom), 30);
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned r;
    len_form_e   form;
    logic [63:0] len;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 60) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(0, 12));
      end else if (r < 65) begin
        form = FORM_SHORT;
        len  = 64'($urandom_range(100, 125));
      end else if (r < 82) begin
        form = FORM_EXT16;
        len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                           : 64'($urandom_range(0, 20));
      end else begin
        form = FORM_EXT64;
        len  = 64'($urandom_range(0, 20));
      end
      send_frame(8'($urandom), 1'($urandom), form, len, $urandom, int'(len));
    end
    drain_results();
  endtask

  // all-ones 64-bit length: counted down without a top-bit check, never ends
  task automatic test_huge_length();
    rx_mode = RX_RANDOM;
    send_frame(8'h82, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 32'($urandom), 12);
    s_tvalid <= 1'b0;
  endtask

  // receiver stall pattern, plus a long hold-off on request
  initial begin : receiver
    int unsigned cnt;
    cnt = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 70);
          default:   m_tready <= ((cnt % 7) < 4);
        endcase
        cnt++;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t e;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        err_cnt++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, m_tuser[0]);
        check_field("fin", e.hdr.fin, m_tdata[0]);
        check_field("rsv1", e.hdr.rsv1, m_tdata[1]);
        check_field("rsv2", e.hdr.rsv2, m_tdata[2]);
        check_field("rsv3", e.hdr.rsv3, m_tdata[3]);
        check_field("opcode", e.hdr.opcode, m_tdata[7:4]);
        check_field("masked", e.hdr.masked, m_tdata[8]);
        check_field("pay_len", e.pay_len, m_tdata[72:9]);
        check_field("mask_key", e.mask_key, m_tdata[104:73]);
        check_field("payload_byte", e.payload_byte, m_tdata[112:105]);
        check_field("last", e.last, m_tlast);
      end
    end
  end

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("tb_websocket_frame_parser_top NOT OK");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    m_tready    = 1'b0;
    err_cnt     = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    rx_hold_len = 0;
    rx_mode     = RX_ALWAYS;
    ph          = PH_B0;
    hdr         = '0;
    len_acc     = 64'd0;
    fld_cnt     = 4'd0;
    key         = 32'd0;
    remaining   = 64'd0;
    kidx        = 2'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frames();
    test_masked_payload();
    test_extended_lengths();
    test_backpressure();
    bytes_sent = 0;
    test_random_frames();
    test_huge_length();

    drain_results();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_websocket_frame_parser_top OK");
    end else begin
      $display("tb_websocket_frame_parser_top NOT OK");
    end
    $finish;
  end

endmodule

>>> websocket_frame_parser_top.f
rtl/core/wsfp_pkg.sv
rtl/core/wsfp_deframer.sv
rtl/core/wsfp_out_reg.sv
rtl/core/websocket_frame_parser_top.sv
test/tb_websocket_frame_parser_top.sv
